// ----- design/lrnac_pkg.sv -----
// Shared constants, types and the root table for the LRN across-channels block.
`default_nettype none

package lrnac_pkg;

   // field widths
   localparam int DATA_W   = 16;
   localparam int DEN_W    = 32;
   localparam int SCALE_W  = 32;
   localparam int EXP_W    = 16;
   localparam int WS_W     = 4;
   localparam int SUM_W    = 40;
   localparam int CNT_W    = 16;
   localparam int SQ_W     = 31;
   localparam int WIN_MAX  = 15;
   localparam int MAX_OUT  = 8;
   localparam int CSR_IDX_W = 2;
   localparam int CSR_DAT_W = 32;

   // register indexes of the csr port
   localparam logic [CSR_IDX_W-1:0] CSR_WINDOW_SIZE = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_SCALE       = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_EXPONENT    = 2'd2;

   // one window cell: the channel value and its square
   typedef struct packed {
      logic signed [DATA_W-1:0] value;
      logic [SQ_W-1:0]          square;
   } cell_word_type;

   typedef logic [31:0] root_tab_type [16];

   // integer square root, digit by digit
   function automatic logic [63:0] isqrt64(input logic [63:0] a_in);
      logic [63:0] a;
      logic [63:0] r;
      logic [63:0] bit_v;
      a = a_in;
      r = '0;
      bit_v = 64'h4000_0000_0000_0000;
      for (int i = 0; i < 32; i++) begin
         if (bit_v > a) bit_v = bit_v >> 2;
      end
      for (int i = 0; i < 32; i++) begin
         if (bit_v != 0) begin
            if (a >= r + bit_v) begin
               a = a - (r + bit_v);
               r = (r >> 1) + bit_v;
            end else begin
               r = r >> 1;
            end
            bit_v = bit_v >> 2;
         end
      end
      return r;
   endfunction

   // entry j holds 2^(-2^-(j+1)) in Q0.32
   function automatic root_tab_type make_roots();
      root_tab_type t;
      logic [63:0] v;
      v = isqrt64(64'h8000_0000_0000_0000);
      t[0] = v[31:0];
      for (int j = 1; j < 16; j++) begin
         v = isqrt64({t[j-1], 32'h0});
         t[j] = v[31:0];
      end
      return t;
   endfunction

   localparam root_tab_type ROOTS = make_roots();

endpackage

`default_nettype wire

// ----- design/lrnac_cell.sv -----
// One window cell: holds a channel value and its square, passes them on at each shift.
`default_nettype none

module lrnac_cell (
   input  wire logic                    clock,
   input  wire logic                    shift,
   input  wire lrnac_pkg::cell_word_type word_in,
   output lrnac_pkg::cell_word_type     word_out
);
   import lrnac_pkg::*;

   cell_word_type word_ff;
   cell_word_type word_in_mux;

   // take the neighbor's word on a shift, hold otherwise
   always_comb begin
      word_in_mux = shift ? word_in : word_ff;
   end

   always_ff @(posedge clock) begin
      word_ff <= word_in_mux;
   end

   assign word_out = word_ff;

endmodule

`default_nettype wire

// ----- design/lrn_across_channels_forward.sv -----
// Top level: LRN across channels, forward pass, with cell chain and log2/exp2 sequencer.
//
// Channel words enter one at a time and shift into a chain of 15 cells that
// hold each value and its square. An input word that releases no result
// leaves the block idle and ready for the next word. Each result then passes
// through setup, a sum over the channels in its window (up to 15) at one
// channel per cycle, the denominator, a normalization step, the 16-step log2
// loop, the exponent product, the 16-step exp2 loop and the final scaling,
// which waits while the output register is full; the two loops share one
// multiplier each. The next input word is taken as soon as the last result
// of the current word sits in the output register.
`default_nettype none

module lrn_across_channels_forward (
   input  wire logic                                   clock,
   input  wire logic                                   reset,
   input  wire logic                                   req_valid,
   output logic                                        req_ready,
   input  wire logic signed [lrnac_pkg::DATA_W-1:0]    req_sample,
   input  wire logic                                   req_last,
   output logic                                        rsp_valid,
   input  wire logic                                   rsp_ready,
   output logic signed [lrnac_pkg::DATA_W-1:0]         rsp_normalized,
   output logic [lrnac_pkg::DEN_W-1:0]                 rsp_denominator,
   output logic                                        rsp_final_res,
   input  wire logic                                   csr_valid,
   output logic                                        csr_ready,
   input  wire logic [lrnac_pkg::CSR_IDX_W-1:0]        csr_index,
   input  wire logic [lrnac_pkg::CSR_DAT_W-1:0]        csr_data
);
   import lrnac_pkg::*;

   localparam logic [3:0] S_IDLE  = 4'd0;
   localparam logic [3:0] S_SETUP = 4'd1;
   localparam logic [3:0] S_SUM   = 4'd2;
   localparam logic [3:0] S_DEN1  = 4'd3;
   localparam logic [3:0] S_DEN2  = 4'd4;
   localparam logic [3:0] S_LOG0  = 4'd5;
   localparam logic [3:0] S_LOG   = 4'd6;
   localparam logic [3:0] S_TMUL  = 4'd7;
   localparam logic [3:0] S_EXP   = 4'd8;
   localparam logic [3:0] S_OMUL  = 4'd9;
   localparam logic [3:0] S_ORND  = 4'd10;

   // registers
   logic [3:0]          state_ff, state_in;
   logic [WS_W-1:0]     ws_ff, ws_in;
   logic [SCALE_W-1:0]  scale_ff, scale_in;
   logic [EXP_W-1:0]    exp_ff, exp_in;
   logic [CNT_W-1:0]    chan_ff, chan_in;
   logic [CNT_W-1:0]    emit_ff, emit_in;
   logic [CNT_W-1:0]    p_ff, p_in;
   logic [CNT_W-1:0]    n_ff, n_in;
   logic [3:0]          cnt_ff, cnt_in;
   logic [2:0]          i_ff, i_in;
   logic                last_ff, last_in;
   logic [2:0]          half_ff, half_in;
   logic [2:0]          ahead_ff, ahead_in;
   logic                empty_ff, empty_in;
   logic [CNT_W-1:0]    d_ff, d_in;
   logic [3:0]          k_ff, k_in;
   logic [3:0]          kend_ff, kend_in;
   logic [SUM_W-1:0]    sum_ff, sum_in;
   logic [63:0]         plo_ff, plo_in;
   logic [39:0]         phi_ff, phi_in;
   logic [DEN_W-1:0]    den_ff, den_in;
   logic [31:0]         m_ff, m_in;
   logic [15:0]         frac_ff, frac_in;
   logic [3:0]          e_ff, e_in;
   logic [3:0]          step_ff, step_in;
   logic [35:0]         t_ff, t_in;
   logic [32:0]         r_ff, r_in;
   logic [48:0]         prod_ff, prod_in;
   logic                neg_ff, neg_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [DATA_W-1:0]   rsp_norm_ff, rsp_norm_in;
   logic [DEN_W-1:0]    rsp_den_ff, rsp_den_in;
   logic                rsp_fin_ff, rsp_fin_in;

   // cell chain
   cell_word_type cells [WIN_MAX];
   cell_word_type head_word;
   logic          shift;
   logic [15:0]   head_mag;
   logic [31:0]   head_sq;
   logic [3:0]    rd_idx;
   cell_word_type rd_word;

   logic req_fire;
   logic out_free;

   assign req_ready = (state_ff == S_IDLE);
   assign req_fire  = req_valid && req_ready;
   assign csr_ready = 1'b1;
   assign shift     = req_fire;
   assign out_free  = !rsp_valid_ff || rsp_ready;

   // square of the incoming sample feeds the head cell
   always_comb begin
      head_mag = req_sample[DATA_W-1] ? 16'(-req_sample) : 16'(req_sample);
      head_sq  = head_mag * head_mag;
      head_word.value  = req_sample;
      head_word.square = head_sq[SQ_W-1:0];
   end

   genvar g;
   generate
      for (g = 0; g < WIN_MAX; g++) begin : g_cell
         if (g == 0) begin : g_head
            lrnac_cell u_cell (
               .clock   (clock),
               .shift   (shift),
               .word_in (head_word),
               .word_out(cells[g])
            );
         end else begin : g_body
            lrnac_cell u_cell (
               .clock   (clock),
               .shift   (shift),
               .word_in (cells[g-1]),
               .word_out(cells[g])
            );
         end
      end
   endgenerate

   // single read port into the chain
   always_comb begin
      rd_idx  = (state_ff == S_SUM) ? k_ff : d_ff[3:0];
      rd_word = (rd_idx < 4'(WIN_MAX)) ? cells[rd_idx] : '0;
   end

   // next-state logic
   logic [2:0]  a_half, a_ahead;
   logic [3:0]  ws_m1;
   logic [CNT_W-1:0] a_p;
   logic [16:0] a_cnt_raw;
   logic [3:0]  a_cnt;
   logic [CNT_W-1:0] s_d;
   logic [CNT_W-1:0] s_kmin;
   logic [16:0] s_kmax17;
   logic [16:0] s_kmax;
   logic [4:0]  lead;
   logic [31:0] norm;
   logic [63:0] msq;
   logic [31:0] mnext;
   logic [15:0] fbits;
   logic [64:0] rmul;
   logic [15:0] mag;
   logic [5:0]  ip;
   logic [5:0]  sh;
   logic [48:0] shifted;
   logic [19:0] q;
   logic [DATA_W-1:0] res;
   logic [40:0] dsum;

   always_comb begin
      state_in = state_ff;
      ws_in = ws_ff; scale_in = scale_ff; exp_in = exp_ff;
      chan_in = chan_ff; emit_in = emit_ff; p_in = p_ff; n_in = n_ff;
      cnt_in = cnt_ff; i_in = i_ff; last_in = last_ff;
      half_in = half_ff; ahead_in = ahead_ff; empty_in = empty_ff;
      d_in = d_ff; k_in = k_ff; kend_in = kend_ff; sum_in = sum_ff;
      plo_in = plo_ff; phi_in = phi_ff; den_in = den_ff;
      m_in = m_ff; frac_in = frac_ff; e_in = e_ff; step_in = step_ff;
      t_in = t_ff; r_in = r_ff; prod_in = prod_ff; neg_in = neg_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_norm_in = rsp_norm_ff; rsp_den_in = rsp_den_ff; rsp_fin_in = rsp_fin_ff;

      // window geometry for the current size
      ws_m1   = ws_ff - 4'd1;
      a_half  = (ws_ff == 4'd0) ? 3'd0 : ws_m1[3:1];
      a_ahead = (ws_ff == 4'd0) ? 3'd0 : 3'(ws_m1 - {1'b0, ws_m1[3:1]});
      a_p     = chan_ff - emit_ff;
      if (req_last) a_cnt_raw = {1'b0, a_p} + 17'd1;
      else if (a_p >= 16'(a_ahead)) a_cnt_raw = {1'b0, a_p - 16'(a_ahead)} + 17'd1;
      else a_cnt_raw = '0;
      a_cnt = (a_cnt_raw > 17'(MAX_OUT)) ? 4'(MAX_OUT) : a_cnt_raw[3:0];

      s_d      = p_ff - 16'(i_ff);
      s_kmin   = (s_d > 16'(ahead_ff)) ? s_d - 16'(ahead_ff) : '0;
      s_kmax17 = {1'b0, s_d} + 17'(half_ff);
      s_kmax   = s_kmax17;
      if (s_kmax > {1'b0, n_ff}) s_kmax = {1'b0, n_ff};
      if (s_kmax > 17'(WIN_MAX - 1)) s_kmax = 17'(WIN_MAX - 1);

      lead = 5'd16;
      for (int b = 16; b < 32; b++) begin
         if (den_ff[b]) lead = 5'(b);
      end
      norm = den_ff << (5'd31 - lead);

      msq   = m_ff * m_ff;
      mnext = msq[61:30];

      fbits = t_ff[29:14];
      rmul  = r_ff * ROOTS[step_ff];

      mag = rd_word.value[DATA_W-1] ? 16'(-rd_word.value) : 16'(rd_word.value);

      ip      = t_ff[35:30];
      sh      = 6'd31 + {1'b0, ip[4:0]};
      shifted = prod_ff >> sh;
      q       = ip[5] ? 20'd0 : (20'(shifted[18:0]) + 20'd1) >> 1;
      if (!neg_ff) res = (q > 20'd32767) ? 16'h7FFF : q[15:0];
      else res = (q > 20'd32768) ? 16'h8000 : 16'(-q[15:0]);

      dsum = {1'b0, phi_ff} + 41'(plo_ff[63:32]) + 41'd65536;

      // configuration writes
      if (csr_valid) begin
         case (csr_index)
            CSR_WINDOW_SIZE: ws_in = csr_data[WS_W-1:0];
            CSR_SCALE:       scale_in = csr_data[SCALE_W-1:0];
            CSR_EXPONENT:    exp_in = csr_data[EXP_W-1:0];
            default: ;
         endcase
      end

      case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               n_in = chan_ff;
               p_in = a_p;
               cnt_in = a_cnt;
               last_in = req_last;
               half_in = a_half;
               ahead_in = a_ahead;
               empty_in = (ws_ff == 4'd0);
               i_in = '0;
               chan_in = req_last ? '0 : chan_ff + 16'd1;
               emit_in = req_last ? '0 : emit_ff + 16'(a_cnt);
               if (a_cnt != 4'd0) state_in = S_SETUP;
            end
         end
         S_SETUP: begin
            d_in = s_d;
            sum_in = '0;
            k_in = s_kmin[3:0];
            kend_in = s_kmax[3:0];
            if (empty_ff || {1'b0, s_kmin} > s_kmax) state_in = S_DEN1;
            else state_in = S_SUM;
         end
         S_SUM: begin
            sum_in = sum_ff + 40'(rd_word.square);
            k_in = k_ff + 4'd1;
            if (k_ff == kend_ff) state_in = S_DEN1;
         end
         S_DEN1: begin
            plo_in = scale_ff * sum_ff[31:0];
            phi_in = scale_ff * sum_ff[39:32];
            state_in = S_DEN2;
         end
         S_DEN2: begin
            den_in = dsum[40:32] != 9'd0 ? 32'hFFFF_FFFF : dsum[31:0];
            state_in = S_LOG0;
         end
         S_LOG0: begin
            m_in = {1'b0, norm[31:1]};
            e_in = 4'(lead - 5'd16);
            frac_in = '0;
            step_in = '0;
            state_in = S_LOG;
         end
         S_LOG: begin
            if (mnext[31]) begin
               m_in = mnext >> 1;
               frac_in = {frac_ff[14:0], 1'b1};
            end else begin
               m_in = mnext;
               frac_in = {frac_ff[14:0], 1'b0};
            end
            step_in = step_ff + 4'd1;
            if (step_ff == 4'd15) state_in = S_TMUL;
         end
         S_TMUL: begin
            t_in = exp_ff * {e_ff, frac_ff};
            r_in = 33'h1_0000_0000;
            step_in = '0;
            state_in = S_EXP;
         end
         S_EXP: begin
            if (fbits[4'd15 - step_ff]) r_in = rmul[64:32];
            step_in = step_ff + 4'd1;
            if (step_ff == 4'd15) state_in = S_OMUL;
         end
         S_OMUL: begin
            if (d_ff < 16'(WIN_MAX)) begin
               prod_in = mag * r_ff;
               neg_in = rd_word.value[DATA_W-1];
            end else begin
               prod_in = '0;
               neg_in = 1'b0;
            end
            state_in = S_ORND;
         end
         S_ORND: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_norm_in = res;
               rsp_den_in = den_ff;
               rsp_fin_in = last_ff && (d_ff == '0);
               i_in = i_ff + 3'd1;
               if ({1'b0, i_ff} + 4'd1 == cnt_ff) state_in = S_IDLE;
               else state_in = S_SETUP;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         ws_ff <= 4'd5;
         scale_ff <= 32'd85899;
         exp_ff <= 16'd12288;
         chan_ff <= '0;
         emit_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         ws_ff <= ws_in;
         scale_ff <= scale_in;
         exp_ff <= exp_in;
         chan_ff <= chan_in;
         emit_ff <= emit_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      p_ff <= p_in; n_ff <= n_in; cnt_ff <= cnt_in; i_ff <= i_in;
      last_ff <= last_in; half_ff <= half_in; ahead_ff <= ahead_in;
      empty_ff <= empty_in; d_ff <= d_in; k_ff <= k_in; kend_ff <= kend_in;
      sum_ff <= sum_in; plo_ff <= plo_in; phi_ff <= phi_in; den_ff <= den_in;
      m_ff <= m_in; frac_ff <= frac_in; e_ff <= e_in; step_ff <= step_in;
      t_ff <= t_in; r_ff <= r_in; prod_ff <= prod_in; neg_ff <= neg_in;
      rsp_norm_ff <= rsp_norm_in; rsp_den_ff <= rsp_den_in; rsp_fin_ff <= rsp_fin_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_normalized  = rsp_norm_ff;
   assign rsp_denominator = rsp_den_ff;
   assign rsp_final_res   = rsp_fin_ff;

endmodule

`default_nettype wire

// ----- design/lrnac_checker.sv -----
// Port-level checks for the LRN block, bound to the top level.
`default_nettype none

module lrnac_checker (
   input wire logic                                clock,
   input wire logic                                reset,
   input wire logic                                req_valid,
   input wire logic                                req_ready,
   input wire logic                                rsp_valid,
   input wire logic                                rsp_ready,
   input wire logic signed [lrnac_pkg::DATA_W-1:0] rsp_normalized,
   input wire logic [lrnac_pkg::DEN_W-1:0]         rsp_denominator,
   input wire logic                                rsp_final_res
);
   import lrnac_pkg::*;

   // a pending result word holds until taken
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_denominator)
         && $stable(rsp_normalized) && $stable(rsp_final_res))
      else $error("result word changed while stalled");

   // denominator is never below one
   a_den_min: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_denominator >= 32'h0001_0000)
      else $error("denominator below 1.0");

   // no result right after reset
   a_rst: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("result valid after reset");

   // a new result word only comes out of a busy block
   a_busy: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(!req_ready))
      else $error("result word appeared while input was open");

   // an offered input word stays offered until taken
   a_req_hold: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_ready |=> req_valid)
      else $error("input word withdrawn before accept");

endmodule

bind lrn_across_channels_forward lrnac_checker u_lrnac_checker (
   .clock          (clock),
   .reset          (reset),
   .req_valid      (req_valid),
   .req_ready      (req_ready),
   .rsp_valid      (rsp_valid),
   .rsp_ready      (rsp_ready),
   .rsp_normalized (rsp_normalized),
   .rsp_denominator(rsp_denominator),
   .rsp_final_res  (rsp_final_res)
);

`default_nettype wire

// ----- bench/tb_lrn_across_channels_forward.sv -----
// Testbench for lrn_across_channels_forward: random pixels checked word by word against a predictor.
`default_nettype none

module tb_lrn_across_channels_forward;
   import lrnac_pkg::*;

   localparam int WATCHDOG_LIMIT = 40000;
   localparam int SETTLE_CYCLES  = 900;

   typedef struct {
      logic [15:0] sample;
      logic        last;
   } chan_word_type;

   typedef struct {
      logic [15:0] normalized;
      logic [31:0] denominator;
      logic        final_res;
   } norm_word_type;

   logic clock = 0;
   logic reset = 1;
   logic req_valid = 0;
   logic req_ready;
   logic signed [DATA_W-1:0] req_sample = '0;
   logic req_last = 0;
   logic rsp_valid;
   logic rsp_ready = 0;
   logic signed [DATA_W-1:0] rsp_normalized;
   logic [DEN_W-1:0] rsp_denominator;
   logic rsp_final_res;
   logic csr_valid = 0;
   logic csr_ready;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [CSR_DAT_W-1:0] csr_data = '0;

   lrn_across_channels_forward dut (.*);

   always #5 clock = ~clock;

   chan_word_type pending_words[$];
   norm_word_type expected_norms[$];
   int errors = 0;
   bit long_hold_req = 0;

   // predictor state and its copy of the registers
   logic [15:0] win_vals [WIN_MAX];
   logic [15:0] seen_cnt, done_cnt;
   logic [3:0]  cfg_window;
   logic [31:0] cfg_scale;
   logic [15:0] cfg_exponent;
   longint unsigned half_roots [16];

   function automatic longint unsigned int_sqrt(longint unsigned a);
      longint unsigned r, b;
      r = 0;
      b = 64'h4000_0000_0000_0000;
      while (b > a) b >>= 2;
      while (b != 0) begin
         if (a >= r + b) begin
            a -= r + b;
            r = (r >> 1) + b;
         end else begin
            r >>= 1;
         end
         b >>= 2;
      end
      return r;
   endfunction

   function automatic longint signed to_signed(logic [15:0] v);
      return longint'(signed'(v));
   endfunction

   // log2 of d/1.0 in Q4.16
   function automatic longint unsigned log2_fix(longint unsigned d);
      int e;
      longint unsigned m, frac;
      e = 31;
      frac = 0;
      while (e > 16 && d[e] == 1'b0) e--;
      m = (e <= 30) ? (d << (30 - e)) : (d >> 1);
      for (int i = 0; i < 16; i++) begin
         m = (m * m) >> 30;
         frac <<= 1;
         if (m >= 64'h8000_0000) begin
            frac |= 1;
            m >>= 1;
         end
      end
      return (longint'(e - 16) << 16) | frac;
   endfunction

   function automatic norm_word_type norm_one(int d, int n, int half, int ahead, bit empty,
                                              bit fin);
      norm_word_type o;
      longint unsigned sum, den, t, ip, f, r, mag, prod, q, s;
      longint signed x, res, v;
      int kmin, kmax;
      sum = 0;
      if (!empty) begin
         kmin = d > ahead ? d - ahead : 0;
         kmax = d + half;
         if (kmax > n) kmax = n;
         if (kmax > WIN_MAX - 1) kmax = WIN_MAX - 1;
         for (int k = kmin; k <= kmax; k++) begin
            v = to_signed(win_vals[k]);
            if (v < 0) v = -v;
            sum += longint'(v * v);
            if (sum > 64'hFF_FFFF_FFFF) sum = 64'hFF_FFFF_FFFF;
         end
      end
      den = longint'(cfg_scale) * (sum >> 32)
            + ((longint'(cfg_scale) * (sum & 64'hFFFF_FFFF)) >> 32) + 65536;
      if (den > 64'hFFFF_FFFF) den = 64'hFFFF_FFFF;
      t = longint'(cfg_exponent) * log2_fix(den);
      ip = t >> 30;
      f = (t >> 14) & 64'hFFFF;
      r = 64'h1_0000_0000;
      for (int j = 0; j < 16; j++)
         if (f[15-j]) r = (r * half_roots[j]) >> 32;
      x = (d < WIN_MAX) ? to_signed(win_vals[d]) : 0;
      mag = (x < 0) ? -x : x;
      prod = mag * r;
      s = 32 + ip;
      q = (s >= 64) ? 0 : ((prod + (64'd1 << (s - 1))) >> s);
      res = (x < 0) ? -longint'(q) : longint'(q);
      if (res > 32767) res = 32767;
      if (res < -32768) res = -32768;
      o.normalized = res[15:0];
      o.denominator = den[31:0];
      o.final_res = fin;
      return o;
   endfunction

   // shift in one channel word and queue the results it releases
   task automatic predict_word(chan_word_type w);
      int n, p, cnt, sz, half, ahead;
      bit empty;
      for (int k = WIN_MAX - 1; k > 0; k--) win_vals[k] = win_vals[k-1];
      win_vals[0] = w.sample;
      n = seen_cnt;
      seen_cnt = seen_cnt + 16'd1;
      sz = cfg_window > WIN_MAX ? WIN_MAX : cfg_window;
      empty = (sz == 0);
      half = empty ? 0 : (sz - 1) / 2;
      ahead = empty ? 0 : sz - 1 - half;
      p = (n - done_cnt) & 16'hFFFF;
      if (w.last) cnt = p + 1;
      else cnt = (p >= ahead) ? p - ahead + 1 : 0;
      if (cnt > MAX_OUT) cnt = MAX_OUT;
      for (int i = 0; i < cnt; i++) begin
         expected_norms.push_back(norm_one(p - i, n, half, ahead, empty,
                                           w.last && (p - i) == 0));
         done_cnt = done_cnt + 16'd1;
      end
      if (w.last) begin
         seen_cnt = 0;
         done_cnt = 0;
      end
   endtask

   initial begin
      half_roots[0] = int_sqrt(64'h8000_0000_0000_0000);
      for (int j = 1; j < 16; j++) half_roots[j] = int_sqrt(half_roots[j-1] << 32);
      foreach (win_vals[k]) win_vals[k] = '0;
      seen_cnt = 0;
      done_cnt = 0;
      cfg_window = 5;
      cfg_scale = 85899;
      cfg_exponent = 12288;
   end

   // predictor follows accepted words and register writes
   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && req_ready) predict_word('{req_sample, req_last});
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_WINDOW_SIZE: cfg_window = csr_data[3:0];
               CSR_SCALE:       cfg_scale = csr_data;
               CSR_EXPONENT:    cfg_exponent = csr_data[15:0];
               default: ;
            endcase
         end
      end
   end

   // sender: bursts of words with random gaps
   int burst_left = 0, gap_left = 0;
   always @(posedge clock) begin
      chan_word_type w;
      if (reset) begin
         req_valid <= 0;
      end else if (!req_valid || req_ready) begin
         if (gap_left > 0) begin
            gap_left--;
            req_valid <= 0;
         end else if (pending_words.size() > 0) begin
            w = pending_words.pop_front();
            req_valid <= 1;
            req_sample <= w.sample;
            req_last <= w.last;
            if (burst_left > 0) begin
               burst_left--;
            end else begin
               burst_left = $urandom_range(0, 12);
               gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
            end
         end else begin
            req_valid <= 0;
         end
      end
   end

   // receiver: own stall pattern, plus one long hold-off on request
   int hold_left = 0;
   bit hold_done = 0;
   int stall_mode = 0;
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 0;
      end else if (long_hold_req && !hold_done) begin
         hold_done = 1;
         hold_left = 500;
         rsp_ready <= 0;
      end else if (hold_left > 0) begin
         hold_left--;
         rsp_ready <= 0;
      end else begin
         if ($urandom_range(0, 63) == 0) stall_mode = $urandom_range(0, 2);
         case (stall_mode)
            0: rsp_ready <= 1;
            1: rsp_ready <= ($urandom_range(0, 3) != 0);
            default: rsp_ready <= ($urandom_range(0, 3) == 0);
         endcase
      end
   end

   // result checker
   always @(posedge clock) begin
      norm_word_type e;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_norms.size() == 0) begin
            errors++;
            $display("%0t: unexpected word norm=%h den=%h fin=%b", $time,
                     rsp_normalized, rsp_denominator, rsp_final_res);
         end else begin
            e = expected_norms.pop_front();
            if (rsp_normalized !== e.normalized) begin
               errors++;
               $display("%0t: normalized expected %h actual %h", $time, e.normalized,
                        rsp_normalized);
            end
            if (rsp_denominator !== e.denominator) begin
               errors++;
               $display("%0t: denominator expected %h actual %h", $time, e.denominator,
                        rsp_denominator);
            end
            if (rsp_final_res !== e.final_res) begin
               errors++;
               $display("%0t: final_res expected %b actual %b", $time, e.final_res,
                        rsp_final_res);
            end
         end
      end
   end

   // watchdog on cycles with no handshake at all
   int quiet_cycles = 0;
   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || (csr_valid && csr_ready))
         quiet_cycles = 0;
      else
         quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("tb_lrn_across_channels_forward failed");
         $finish;
      end
   end

   task automatic write_reg(logic [CSR_IDX_W-1:0] idx, logic [31:0] val);
      @(posedge clock);
      csr_valid <= 1;
      csr_index <= idx;
      csr_data <= val;
      do @(posedge clock); while (!(csr_valid && csr_ready));
      csr_valid <= 0;
   endtask

   task automatic wait_drained();
      do @(posedge clock);
      while (pending_words.size() != 0 || req_valid || expected_norms.size() != 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   function automatic logic [15:0] rand_sample(int kind);
      case (kind)
         0: return 16'($urandom());
         1: return 16'($urandom_range(0, 1023) - 512);
         default: return ($urandom_range(0, 1)) ? 16'h7FFF : 16'h8000;
      endcase
   endfunction

   task automatic add_pixel(int len, int kind, bit close = 1);
      for (int i = 0; i < len; i++)
         pending_words.push_back('{rand_sample($urandom_range(0, 5) == 0 ? 2 : kind),
                                   close && i == len - 1});
   endtask

   task automatic add_random(int words);
      int len;
      while (words > 0) begin
         len = $urandom_range(1, 14);
         add_pixel(len, $urandom_range(0, 1));
         words -= len;
      end
   endtask

   initial begin
      repeat (4) @(posedge clock);
      reset <= 0;

      // directed: extremes, single channel pixel, default registers
      pending_words.push_back('{16'h7FFF, 1'b0});
      pending_words.push_back('{16'h8000, 1'b0});
      pending_words.push_back('{16'h0000, 1'b0});
      pending_words.push_back('{16'hFFFF, 1'b0});
      pending_words.push_back('{16'h0001, 1'b1});
      pending_words.push_back('{16'h8000, 1'b1});
      add_pixel(12, 2);
      wait_drained();

      // empty window, then window change inside a pixel
      write_reg(CSR_WINDOW_SIZE, 0);
      add_pixel(4, 0);
      add_pixel(3, 0, 0);
      wait_drained();
      write_reg(CSR_WINDOW_SIZE, 7);
      add_pixel(5, 0, 0);
      wait_drained();
      write_reg(CSR_WINDOW_SIZE, 2);
      add_pixel(2, 0);
      wait_drained();

      // largest window with largest scale and power
      write_reg(CSR_WINDOW_SIZE, 15);
      write_reg(CSR_SCALE, 32'hFFFF_FFFF);
      write_reg(CSR_EXPONENT, 32'h0000_FFFF);
      add_pixel(16, 2);
      add_random(20);
      wait_drained();

      // zero scale and power, long hold-off at the receiver
      write_reg(CSR_WINDOW_SIZE, 1);
      write_reg(CSR_SCALE, 0);
      write_reg(CSR_EXPONENT, 0);
      long_hold_req = 1;
      add_random(40);
      wait_drained();

      for (int ph = 0; ph < 3; ph++) begin
         write_reg(CSR_WINDOW_SIZE, $urandom_range(0, 15));
         write_reg(CSR_SCALE, ($urandom_range(0, 1)) ? $urandom() : $urandom_range(0, 1 << 20));
         write_reg(CSR_EXPONENT, $urandom_range(0, 65535));
         add_random(28);
         wait_drained();
      end

      if (errors == 0)
         $display("tb_lrn_across_channels_forward passed");
      else
         $display("tb_lrn_across_channels_forward failed");
      $finish;
   end

endmodule

`default_nettype wire
